// File: sv/kmcd_pkg.sv
// Shared types and constants for the key matrix chatter debounce block.
// Used by the top level and its port list; depends on nothing else.
`timescale 1ns / 1ps

package kmcd_pkg;

  // one scanned key sample
  typedef struct packed {
    logic [6:0]  key_index;
    logic        key_down;
    logic [15:0] scan_period;
  } sample_t;

  // one debounced result
  typedef struct packed {
    logic pressing;
    logic pressed_edge;
    logic released_edge;
    logic changed;
  } result_t;

  // per-key signed run count
  typedef logic signed [15:0] count_t;

  localparam count_t      CNT_MAX     = 16'sd32767;
  localparam count_t      CNT_MIN     = -16'sd32767;
  localparam logic [31:0] LIMIT_RESET = 32'd8000;

  // register select bit of paddr (word index)
  localparam logic REG_CHATTER_LIMIT = 1'b0;

endpackage

// File: sv/key_matrix_chatter_debounce.sv
// Key matrix chatter debounce: per-key run counters held in one RAM.
// A sample is read from RAM into stage 1, then updated, written back and registered out.
// One sample per cycle unless clearing or stalled; same-key repeats use write forwarding.
// Reset: synchronous; chatter_limit returns to 8000 and a clearing pass zeroes each
// counter RAM address in turn, during which no sample is taken (config writes still are).
`timescale 1ns / 1ps

module key_matrix_chatter_debounce #(
  parameter int KEYS = 128
) (
  input  logic               clk,
  input  logic               rst,
  // sample channel
  input  logic               sample_valid,
  output logic               sample_ready,
  input  kmcd_pkg::sample_t  sample,
  // result channel
  output logic               result_valid,
  input  logic               result_ready,
  output kmcd_pkg::result_t  result,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  import kmcd_pkg::*;

  localparam int AW = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int EW = AW + 7;

  // configuration register
  logic [31:0] chatter_limit;

  // clearing pass
  logic          clr_active;
  logic [AW-1:0] clr_addr;

  // stage 1: RAM data ready
  logic          s1_valid;
  logic          s1_in_range;
  logic [AW-1:0] s1_addr;
  logic          s1_down;
  logic [15:0]   s1_period;

  // write forward for a same-key sample read at the write edge
  logic          fwd_valid;
  logic [AW-1:0] fwd_addr;
  count_t        fwd_data;

  logic [EW-1:0] idx_ext;
  logic          in_range;
  logic [AW-1:0] rd_addr;
  logic          accept;
  logic          s1_go;
  logic [15:0]   ram_rdata;
  count_t        c;
  count_t        c_next;
  logic          prev;
  logic          neg;
  logic [15:0]   mag;
  logic [31:0]   prod;
  logic          reversal;
  count_t        step_up;
  count_t        step_dn;
  logic          now;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  count_t        ram_wdata;
  result_t       result_next;

  // configuration access
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CHATTER_LIMIT) ? chatter_limit : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      chatter_limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CHATTER_LIMIT) begin
      chatter_limit <= pwdata;
    end
  end

  // key index decode
  assign idx_ext  = {{AW{1'b0}}, sample.key_index};
  assign in_range = idx_ext < EW'(KEYS);
  assign rd_addr  = idx_ext[AW-1:0];

  // handshake
  assign s1_go        = s1_valid && (!result_valid || result_ready);
  assign sample_ready = !clr_active && (!s1_valid || s1_go);
  assign accept       = sample_valid && sample_ready;

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      if (clr_addr == AW'(KEYS - 1)) begin
        clr_active <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // counter RAM
  assign ram_we    = clr_active || (s1_go && s1_in_range);
  assign ram_waddr = clr_active ? clr_addr : s1_addr;
  assign ram_wdata = clr_active ? count_t'(0) : c_next;

  kmcd_ram #(
    .WIDTH(16),
    .DEPTH(KEYS)
  ) u_cnt_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (accept),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  // stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_in_range <= in_range;
      s1_addr     <= rd_addr;
      s1_down     <= sample.key_down;
      s1_period   <= sample.scan_period;
    end
  end

  // forward capture: set when a write lands at the same edge as a RAM read
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (accept) begin
      fwd_valid <= s1_go && s1_in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_addr <= s1_addr;
      fwd_data <= c_next;
    end
  end

  // read-modify: current count with forwarding
  assign c = (fwd_valid && fwd_addr == s1_addr) ? fwd_data : count_t'(ram_rdata);

  assign neg      = c[15];
  assign prev     = !neg && (c != count_t'(0));
  assign mag      = neg ? 16'(-c) : 16'(c);
  assign prod     = {16'd0, mag} * {16'd0, s1_period};
  assign reversal = s1_down ? neg : prev;
  assign step_up  = (c < CNT_MAX) ? count_t'(c + count_t'(1)) : c;
  assign step_dn  = (c > CNT_MIN) ? count_t'(c - count_t'(1)) : c;

  // counter update
  always_comb begin
    if (reversal) begin
      if (prod < chatter_limit) begin
        c_next = prev ? step_up : step_dn;
      end else begin
        c_next = s1_down ? count_t'(1) : count_t'(-1);
      end
    end else begin
      c_next = s1_down ? step_up : step_dn;
    end
  end

  // result fields
  assign now = !c_next[15] && (c_next != count_t'(0));

  always_comb begin
    if (s1_in_range) begin
      result_next.pressing      = now;
      result_next.pressed_edge  = now && !prev;
      result_next.released_edge = !now && prev;
      result_next.changed       = now != prev;
    end else begin
      result_next = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_go) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      result <= result_next;
    end
  end

endmodule

// File: sv/kmcd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; read-during-write to the same address returns the old data.
`timescale 1ns / 1ps

module kmcd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
